// File: sv/fps_pkg.sv
`timescale 1ns / 1ps
package fps_pkg;

  localparam logic [30:0] NS_PER_SEC = 31'd1000000000;
  localparam int MUL_STEPS = 31;
  localparam int MUL_CW = 5;
  localparam int DIV_STEPS = 128;
  localparam int DIV_CW = 7;

  typedef enum logic [2:0] {
    ST_GEN_MISMATCH   = 3'd0,
    ST_EPOCH_MISMATCH = 3'd1,
    ST_INVALID        = 3'd2,
    ST_WAIT           = 3'd3,
    ST_DROP           = 3'd4,
    ST_READY          = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_REP_MA, S_REP_MB, S_REP_DEC,
    S_LOOP_MUL, S_LOOP_DIV, S_LOOP_DEC,
    S_NRM_MA, S_NRM_MB, S_NRM_DEC1, S_NRM_MC, S_NRM_MD, S_NRM_DEC2,
    S_NRM_MUL, S_NRM_DIV, S_NRM_DEC3,
    S_FIN
  } fsm_state_t;

  typedef enum logic [2:0] {
    M_PV_LPS, M_LPV_PS, M_PV_APS, M_APV_PS, M_DIFF_NS, M_LDV_NS
  } mul_sel_t;

  typedef enum logic {DEN_SCALES, DEN_DUR} den_sel_t;

  typedef enum logic [2:0] {C_NONE, C_ANCHOR, C_LOOP, C_NORMAL, C_REPEAT} commit_t;

  typedef struct packed {
    logic [31:0]        frame_generation;
    logic [31:0]        frame_epoch;
    logic [31:0]        frame_sequence;
    logic [31:0]        frame_loop;
    logic signed [63:0] pts_value;
    logic [30:0]        pts_scale;
    logic signed [63:0] duration_value;
    logic [30:0]        duration_scale;
    logic [31:0]        current_generation;
    logic [31:0]        current_epoch;
    logic [63:0]        now_ns;
  } in_item_t;

  typedef struct packed {
    logic     capture;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     pa_load;
    logic     diff_load;
    logic     sp_load;
    logic     div_start;
    den_sel_t div_sel;
    commit_t  commit;
    logic     use_dn;
    logic     out_load;
    logic     rej;
    status_t  rej_code;
  } cmd_t;

  typedef struct packed {
    logic gen_mis;
    logic ep_mis;
    logic ps_zero;
    logic need_anchor;
    logic is_repeat;
    logic lps_zero;
    logic aps_zero;
    logic loop_older;
    logic loop_new;
    logic dur_ok;
    logic mul_done;
    logic div_done;
    logic diff_neg;
    logic diff_zero;
    logic q_hi_zero;
    logic q_lo_zero;
    logic ovf_loop;
    logic ovf_norm;
    logic due_lt_last;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// File: sv/fps_in_if.sv
`timescale 1ns / 1ps
interface fps_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        frame_generation;
  logic [31:0]        frame_epoch;
  logic [31:0]        frame_sequence;
  logic [31:0]        frame_loop;
  logic signed [63:0] pts_value;
  logic [30:0]        pts_scale;
  logic signed [63:0] duration_value;
  logic [30:0]        duration_scale;
  logic [31:0]        current_generation;
  logic [31:0]        current_epoch;
  logic [63:0]        now_ns;

  modport source(output valid, frame_generation, frame_epoch, frame_sequence, frame_loop,
                 pts_value, pts_scale, duration_value, duration_scale,
                 current_generation, current_epoch, now_ns, input ready);
  modport sink(input valid, frame_generation, frame_epoch, frame_sequence, frame_loop,
               pts_value, pts_scale, duration_value, duration_scale,
               current_generation, current_epoch, now_ns, output ready);
endinterface

// File: sv/fps_out_if.sv
`timescale 1ns / 1ps
interface fps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        due_valid;
  logic [63:0] due_ns;

  modport source(output valid, status, due_valid, due_ns, input ready);
  modport sink(input valid, status, due_valid, due_ns, output ready);
endinterface

// File: sv/fps_mul.sv
`timescale 1ns / 1ps
module fps_mul import fps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] opa,
  input  logic [30:0]  opb,
  output logic         done,
  output logic [127:0] prod
);

  logic [127:0]      acc_r;
  logic [127:0]      a_r;
  logic [30:0]       b_r;
  logic [MUL_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CW'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per step, shift and add
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= opa;
      b_r   <= opb;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[126:0], 1'b0};
      b_r <= {1'b0, b_r[30:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: sv/fps_div.sv
`timescale 1ns / 1ps
module fps_div import fps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [127:0] quo
);

  logic [127:0]      q_r;
  logic [63:0]       r_r;
  logic [63:0]       den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [64:0]       r2;
  logic              ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per step
  always_comb begin
    r2 = {r_r, q_r[127]};
    ge = (r2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      r_r   <= '0;
      den_r <= den;
    end else if (busy_r) begin
      r_r <= ge ? 64'(r2 - {1'b0, den_r}) : r2[63:0];
      q_r <= {q_r[126:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: sv/fps_dp.sv
`timescale 1ns / 1ps
module fps_dp import fps_pkg::*; #(
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_due_valid,
  output logic [63:0] out_due_ns,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  localparam int IDW = (ID_WIDTH < 32) ? ID_WIDTH : 32;

  logic [63:0]    max_lat_r;
  logic [IDW-1:0] cap_fg_r, cap_fe_r, cap_fs_r, cap_fl_r, cap_cg_r, cap_ce_r;
  logic [63:0]    cap_pv_r, cap_dv_r, cap_now_r;
  logic [30:0]    cap_ps_r, cap_ds_r;

  logic           anchored_r, have_last_r;
  logic [IDW-1:0] ctx_gen_r, ctx_ep_r, ctx_loop_r;
  logic [IDW-1:0] ls_r, lg_r, le_r, ll_r;
  logic [63:0]    apv_r, ha_r, lpv_r, ldv_r, ldue_r;
  logic [30:0]    aps_r, lps_r, lds_r;

  logic [127:0]   pa_r, diff_r, sprod;
  logic           mneg_r;
  logic [61:0]    sp_r;
  logic [63:0]    due_r;

  logic           out_valid_r, out_dv_r;
  logic [2:0]     out_status_r;
  logic [63:0]    out_due_r;

  logic [127:0]   mul_a, mul_p, div_q;
  logic [30:0]    mul_b;
  logic           mul_neg, mul_done, div_done;
  logic [63:0]    div_den;
  logic [64:0]    loop_sum, norm_sum;
  logic [63:0]    base0, loop_base;
  status_t        cls;

  fps_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .opa(mul_a), .opb(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  fps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(mul_p), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (cmd.mul_sel)
      M_PV_LPS: begin
        mul_a = {64'd0, mag64(cap_pv_r)}; mul_b = lps_r; mul_neg = cap_pv_r[63];
      end
      M_LPV_PS: begin
        mul_a = {64'd0, mag64(lpv_r)}; mul_b = cap_ps_r; mul_neg = lpv_r[63];
      end
      M_PV_APS: begin
        mul_a = {64'd0, mag64(cap_pv_r)}; mul_b = aps_r; mul_neg = cap_pv_r[63];
      end
      M_APV_PS: begin
        mul_a = {64'd0, mag64(apv_r)}; mul_b = cap_ps_r; mul_neg = apv_r[63];
      end
      M_DIFF_NS: begin
        mul_a = diff_r; mul_b = NS_PER_SEC;
      end
      M_LDV_NS: begin
        mul_a = {64'd0, ldv_r}; mul_b = NS_PER_SEC;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign div_den = (cmd.div_sel == DEN_SCALES) ? {2'd0, sp_r} : {33'd0, lds_r};
  assign sprod   = mneg_r ? (~mul_p + 128'd1) : mul_p;

  always_comb begin
    loop_sum  = {1'b0, ldue_r} + {1'b0, div_q[63:0]};
    norm_sum  = {1'b0, ha_r} + {1'b0, div_q[63:0]};
    base0     = (cap_now_r > ldue_r) ? cap_now_r : ldue_r;
    loop_base = base0;
    if (cmd.use_dn && (loop_sum[63:0] > base0)) begin
      loop_base = loop_sum[63:0];
    end
  end

  always_comb begin
    sts.gen_mis     = (cap_fg_r != cap_cg_r);
    sts.ep_mis      = (cap_fe_r != cap_ce_r);
    sts.ps_zero     = (cap_ps_r == '0);
    sts.need_anchor = !anchored_r || (ctx_gen_r != cap_cg_r) || (ctx_ep_r != cap_ce_r);
    sts.is_repeat   = have_last_r && (ls_r == cap_fs_r) && (lg_r == cap_fg_r) &&
                      (le_r == cap_fe_r) && (ll_r == cap_fl_r);
    sts.lps_zero    = (lps_r == '0);
    sts.aps_zero    = (aps_r == '0);
    sts.loop_older  = (cap_fl_r < ctx_loop_r);
    sts.loop_new    = (cap_fl_r != ctx_loop_r);
    sts.dur_ok      = (lds_r != '0) && !ldv_r[63] && (ldv_r != '0);
    sts.mul_done    = mul_done;
    sts.div_done    = div_done;
    sts.diff_neg    = diff_r[127];
    sts.diff_zero   = (diff_r == '0);
    sts.q_hi_zero   = (div_q[127:64] == '0);
    sts.q_lo_zero   = (div_q[63:0] == '0);
    sts.ovf_loop    = loop_sum[64];
    sts.ovf_norm    = norm_sum[64];
    sts.due_lt_last = (norm_sum[63:0] < ldue_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    if (cap_now_r < due_r) begin
      cls = ST_WAIT;
    end else if ((cap_now_r - due_r) > max_lat_r) begin
      cls = ST_DROP;
    end else begin
      cls = ST_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lat_r <= '0;
    end else if (cfg_we) begin
      max_lat_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_fg_r  <= in_item.frame_generation[IDW-1:0];
      cap_fe_r  <= in_item.frame_epoch[IDW-1:0];
      cap_fs_r  <= in_item.frame_sequence[IDW-1:0];
      cap_fl_r  <= in_item.frame_loop[IDW-1:0];
      cap_cg_r  <= in_item.current_generation[IDW-1:0];
      cap_ce_r  <= in_item.current_epoch[IDW-1:0];
      cap_pv_r  <= in_item.pts_value;
      cap_ps_r  <= in_item.pts_scale;
      cap_dv_r  <= in_item.duration_value;
      cap_ds_r  <= in_item.duration_scale;
      cap_now_r <= in_item.now_ns;
    end
    if (cmd.mul_start) begin
      mneg_r <= mul_neg;
    end
    if (cmd.pa_load) begin
      pa_r <= sprod;
    end
    if (cmd.diff_load) begin
      diff_r <= pa_r - sprod;
    end
    if (cmd.sp_load) begin
      sp_r <= cap_ps_r * aps_r;
    end
  end

  // frame context and last-frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchored_r  <= 1'b0;
      have_last_r <= 1'b0;
    end else begin
      if (cmd.commit == C_ANCHOR) begin
        anchored_r <= 1'b1;
      end
      if (cmd.commit == C_ANCHOR || cmd.commit == C_LOOP || cmd.commit == C_NORMAL) begin
        have_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.commit)
      C_ANCHOR: begin
        ctx_gen_r  <= cap_cg_r;
        ctx_ep_r   <= cap_ce_r;
        ctx_loop_r <= cap_fl_r;
        apv_r      <= cap_pv_r;
        aps_r      <= cap_ps_r;
        ha_r       <= cap_now_r;
        due_r      <= cap_now_r;
      end
      C_LOOP: begin
        ctx_loop_r <= cap_fl_r;
        apv_r      <= cap_pv_r;
        aps_r      <= cap_ps_r;
        ha_r       <= loop_base;
        due_r      <= loop_base;
      end
      C_NORMAL: begin
        due_r <= norm_sum[63:0];
      end
      C_REPEAT: begin
        due_r <= ldue_r;
      end
      default: begin
      end
    endcase
    if (cmd.commit == C_ANCHOR || cmd.commit == C_LOOP || cmd.commit == C_NORMAL) begin
      ls_r  <= cap_fs_r;
      lg_r  <= cap_fg_r;
      le_r  <= cap_fe_r;
      ll_r  <= cap_fl_r;
      lpv_r <= cap_pv_r;
      lps_r <= cap_ps_r;
      ldv_r <= cap_dv_r;
      lds_r <= cap_ds_r;
    end
    unique case (cmd.commit)
      C_ANCHOR: ldue_r <= cap_now_r;
      C_LOOP:   ldue_r <= loop_base;
      C_NORMAL: ldue_r <= norm_sum[63:0];
      default:  begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.rej) begin
        out_status_r <= cmd.rej_code;
        out_dv_r     <= 1'b0;
        out_due_r    <= '0;
      end else begin
        out_status_r <= cls;
        out_dv_r     <= 1'b1;
        out_due_r    <= due_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_due_valid = out_dv_r;
  assign out_due_ns    = out_due_r;

endmodule

// File: sv/fps_ctrl.sv
`timescale 1ns / 1ps
module fps_ctrl import fps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  logic       rej_r, rej_nxt;
  status_t    code_r, code_nxt;
  logic       loopdur_r, loopdur_nxt;
  logic       use_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rej_r     <= 1'b0;
      code_r    <= ST_INVALID;
      loopdur_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rej_r     <= rej_nxt;
      code_r    <= code_nxt;
      loopdur_r <= loopdur_nxt;
    end
  end

  assign use_dn = loopdur_r && sts.q_hi_zero && !sts.q_lo_zero;

  always_comb begin
    state_nxt   = state_r;
    rej_nxt     = rej_r;
    code_nxt    = code_r;
    loopdur_nxt = loopdur_r;
    in_ready    = (state_r == S_IDLE);
    cmd         = '0;
    cmd.mul_sel = M_PV_LPS;
    cmd.div_sel = DEN_SCALES;
    cmd.commit  = C_NONE;
    cmd.rej_code = code_r;
    cmd.rej     = rej_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        rej_nxt   = 1'b1;
        code_nxt  = ST_INVALID;
        state_nxt = S_FIN;
        priority if (sts.gen_mis) begin
          code_nxt = ST_GEN_MISMATCH;
        end else if (sts.ep_mis) begin
          code_nxt = ST_EPOCH_MISMATCH;
        end else if (sts.ps_zero) begin
          code_nxt = ST_INVALID;
        end else if (sts.need_anchor) begin
          rej_nxt    = 1'b0;
          cmd.commit = C_ANCHOR;
        end else if (sts.is_repeat) begin
          if (!sts.lps_zero) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = M_PV_LPS;
            state_nxt     = S_REP_MA;
          end
        end else if (sts.loop_older) begin
          code_nxt = ST_INVALID;
        end else if (sts.loop_new) begin
          loopdur_nxt = sts.dur_ok;
          if (sts.dur_ok) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = M_LDV_NS;
            state_nxt     = S_LOOP_MUL;
          end else begin
            state_nxt = S_LOOP_DEC;
          end
        end else begin
          if (!sts.lps_zero && !sts.aps_zero) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = M_PV_LPS;
            cmd.sp_load   = 1'b1;
            state_nxt     = S_NRM_MA;
          end
        end
      end
      S_REP_MA: begin
        if (sts.mul_done) begin
          cmd.pa_load   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = M_LPV_PS;
          state_nxt     = S_REP_MB;
        end
      end
      S_REP_MB: begin
        if (sts.mul_done) begin
          cmd.diff_load = 1'b1;
          state_nxt     = S_REP_DEC;
        end
      end
      S_REP_DEC: begin
        state_nxt = S_FIN;
        if (sts.diff_zero) begin
          rej_nxt    = 1'b0;
          cmd.commit = C_REPEAT;
        end
      end
      S_LOOP_MUL: begin
        if (sts.mul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DEN_DUR;
          state_nxt     = S_LOOP_DIV;
        end
      end
      S_LOOP_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LOOP_DEC;
        end
      end
      S_LOOP_DEC: begin
        state_nxt = S_FIN;
        // end of the last frame counts only for a usable duration
        if (!(use_dn && sts.ovf_loop)) begin
          rej_nxt    = 1'b0;
          cmd.commit = C_LOOP;
          cmd.use_dn = use_dn;
        end
      end
      S_NRM_MA: begin
        if (sts.mul_done) begin
          cmd.pa_load   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = M_LPV_PS;
          state_nxt     = S_NRM_MB;
        end
      end
      S_NRM_MB: begin
        if (sts.mul_done) begin
          cmd.diff_load = 1'b1;
          state_nxt     = S_NRM_DEC1;
        end
      end
      S_NRM_DEC1: begin
        if (sts.diff_neg || sts.diff_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = M_PV_APS;
          state_nxt     = S_NRM_MC;
        end
      end
      S_NRM_MC: begin
        if (sts.mul_done) begin
          cmd.pa_load   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = M_APV_PS;
          state_nxt     = S_NRM_MD;
        end
      end
      S_NRM_MD: begin
        if (sts.mul_done) begin
          cmd.diff_load = 1'b1;
          state_nxt     = S_NRM_DEC2;
        end
      end
      S_NRM_DEC2: begin
        if (sts.diff_neg) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = M_DIFF_NS;
          state_nxt     = S_NRM_MUL;
        end
      end
      S_NRM_MUL: begin
        if (sts.mul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DEN_SCALES;
          state_nxt     = S_NRM_DIV;
        end
      end
      S_NRM_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_NRM_DEC3;
        end
      end
      S_NRM_DEC3: begin
        state_nxt = S_FIN;
        if (sts.q_hi_zero && !sts.ovf_norm && !sts.due_lt_last) begin
          rej_nxt    = 1'b0;
          cmd.commit = C_NORMAL;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/frame_presentation_scheduler_unit.sv
`timescale 1ns / 1ps
// Frame presentation scheduler: one result item per input frame, one frame in flight at a
// time. Each frame takes one of these paths through the controller:
//   no multiply or divide for a frame rejected on identity, non-numeric pts or an older
//     loop, for one that anchors a new context, and for a new loop iteration whose last
//     duration does not count
//   two 31-step multiplies for a repeat of the last frame, or for a frame whose pts does
//     not rise
//   four multiplies for a frame whose pts lies before the anchor
//   one multiply and one 128-step divide for a new loop iteration with a usable last
//     duration
//   five multiplies and one divide for an ordinary frame
// The work is done by the shared bit-serial multiplier and the radix-2 restoring divider.
// A finished result waits while the output register stays occupied, and the next frame
// is accepted once the result is parked there. max_lateness_ns is written through
// cfg_we/cfg_wdata; the user must write it only while idle, as the block does not
// enforce this.
module frame_presentation_scheduler_unit import fps_pkg::*; #(
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  fps_in_if.sink      in_ch,
  fps_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  in_item_t in_item;
  cmd_t     cmd;
  sts_t     sts;
  logic     in_ready;

  always_comb begin
    in_item.frame_generation   = in_ch.frame_generation;
    in_item.frame_epoch        = in_ch.frame_epoch;
    in_item.frame_sequence     = in_ch.frame_sequence;
    in_item.frame_loop         = in_ch.frame_loop;
    in_item.pts_value          = in_ch.pts_value;
    in_item.pts_scale          = in_ch.pts_scale;
    in_item.duration_value     = in_ch.duration_value;
    in_item.duration_scale     = in_ch.duration_scale;
    in_item.current_generation = in_ch.current_generation;
    in_item.current_epoch      = in_ch.current_epoch;
    in_item.now_ns             = in_ch.now_ns;
  end

  assign in_ch.ready = in_ready;

  fps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  fps_dp #(.ID_WIDTH(ID_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_status(out_ch.status),
    .out_due_valid(out_ch.due_valid), .out_due_ns(out_ch.due_ns),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

endmodule

// File: sv/fps_checker.sv
`timescale 1ns / 1ps
module fps_checker import fps_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic        out_due_valid,
  input logic [63:0] out_due_ns
);

  // due time is reported exactly for wait, drop and ready
  a_due_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_due_valid == (out_status == ST_WAIT || out_status == ST_DROP ||
                                     out_status == ST_READY)))
    else $error("due_valid does not match status");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_due_valid |-> out_due_ns == 64'd0)
    else $error("rejected item carries a due time");

  // one frame in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

endmodule

bind frame_presentation_scheduler_unit fps_checker u_fps_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_status(out_ch.status),
  .out_due_valid(out_ch.due_valid), .out_due_ns(out_ch.due_ns)
);
